// ----- rtl/ssr_pkg.sv -----
// Shared types and constants for the streaming substring replace block.
// Used by ssr_ctrl, ssr_datapath and stream_substring_replace.
`timescale 1ns / 1ps
`default_nettype none

package ssr_pkg;

  // Default sizes of the window, the replacement and the position counter
  localparam int DEF_MAX_PATTERN = 16;
  localparam int DEF_MAX_REPLACE = 16;
  localparam int DEF_MAX_OUTPUT  = 2048;

  // Bytes held by a pair of 64-bit pattern or replacement registers
  localparam int REG_BYTES  = 16;
  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LOW  = 3'd0,
    REG_PATTERN_HIGH = 3'd1,
    REG_PATTERN_LEN  = 3'd2,
    REG_REPLACE_LOW  = 3'd3,
    REG_REPLACE_HIGH = 3'd4,
    REG_REPLACE_LEN  = 3'd5
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;         // write the accepted input byte into the window
    logic clear_count;  // drop the window after a match
    logic rep_start;    // rewind the replacement byte index
    logic pop;          // emit the oldest window byte and shift
    logic rep_emit;     // emit the current replacement byte
    logic mark;         // emit an empty end-of-string marker
    logic final_beat;   // the emitted beat closes the string
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic slot_free;    // output register can take a beat this cycle
    logic full;         // window holds pattern length bytes
    logic match;        // window equals the pattern
    logic count_one;    // exactly one byte pending in the window
    logic rep_end;      // current replacement byte is the last one
    logic rlen_zero;    // replacement is empty
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/ssr_ctrl.sv -----
// Controller state machine for the streaming substring replace block.
// Depends on ssr_pkg; drives ssr_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ssr_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_last,
  output logic                    in_ready,
  input  wire ssr_pkg::dp_status_t st,
  output ssr_pkg::dp_cmd_t        cmd
);
  import ssr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_POP,
    S_REP,
    S_MARK
  } state_t;

  state_t state;
  logic   last_flag;

  // Decode commands for the current state
  always_comb begin
    cmd      = '0;
    in_ready = (state == S_IDLE);
    unique case (state)
      S_IDLE: begin
        cmd.load = in_valid;
      end
      S_EVAL: begin
        if (st.full && st.match) begin
          cmd.clear_count = 1'b1;
          cmd.rep_start   = 1'b1;
        end
      end
      S_POP: begin
        if (st.slot_free) begin
          cmd.pop        = 1'b1;
          cmd.final_beat = last_flag && st.count_one;
        end
      end
      S_REP: begin
        if (st.slot_free) begin
          cmd.rep_emit   = 1'b1;
          cmd.final_beat = last_flag && st.rep_end;
        end
      end
      S_MARK: begin
        if (st.slot_free) begin
          cmd.mark       = 1'b1;
          cmd.final_beat = 1'b1;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  // Advance the sequence: accept, evaluate, then emit beats
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      last_flag <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            last_flag <= in_last;
            state     <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (st.full) begin
            if (st.match) begin
              if (!st.rlen_zero) begin
                state <= S_REP;
              end else if (last_flag) begin
                state <= S_MARK;
              end else begin
                state <= S_IDLE;
              end
            end else begin
              state <= S_POP;
            end
          end else if (last_flag) begin
            state <= S_POP;
          end else begin
            state <= S_IDLE;
          end
        end
        S_POP: begin
          // one pop on a mismatch, or drain the window at end of string
          if (st.slot_free && (!last_flag || st.count_one)) begin
            state <= S_IDLE;
          end
        end
        S_REP: begin
          if (st.slot_free && st.rep_end) begin
            state <= S_IDLE;
          end
        end
        S_MARK: begin
          if (st.slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ssr_datapath.sv -----
// Datapath for the streaming substring replace block: configuration
// registers, byte window, pattern compare, output register. Uses ssr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssr_datapath #(
  parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACE = ssr_pkg::DEF_MAX_REPLACE,
  parameter int MAX_OUTPUT  = ssr_pkg::DEF_MAX_OUTPUT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [ssr_pkg::BYTE_W-1:0]     in_byte,
  input  wire ssr_pkg::dp_cmd_t               cmd,
  output ssr_pkg::dp_status_t                 st,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [ssr_pkg::BYTE_W-1:0]          out_byte,
  output logic                                out_last,
  output logic                                overflow
);
  import ssr_pkg::*;

  localparam int WIN = (MAX_PATTERN < REG_BYTES) ? MAX_PATTERN : REG_BYTES;
  localparam int REP = (MAX_REPLACE < REG_BYTES) ? MAX_REPLACE : REG_BYTES;
  localparam int CW  = $clog2(WIN + 1);
  localparam int RIW = (REP > 1) ? $clog2(REP) : 1;
  localparam int PW  = $clog2(MAX_OUTPUT + 1);

  logic [CFG_DATA_W-1:0] pattern_low, pattern_high;
  logic [CFG_DATA_W-1:0] replace_low, replace_high;
  logic [LEN_W-1:0]      pattern_len, replace_len;

  logic [REG_BYTES-1:0][BYTE_W-1:0] pat_bytes, rep_bytes;
  logic [LEN_W-1:0]  plen_eff, rlen_eff;
  logic [CW-1:0]     plen_c;

  logic [BYTE_W-1:0] window [WIN];
  logic [CW-1:0]     count;
  logic [CW-1:0]     wr_pos;
  logic [RIW-1:0]    rep_idx;
  logic [PW-1:0]     pos;

  logic              match;
  logic              emit;
  logic [BYTE_W-1:0] emit_byte;
  logic              len_write;

  assign pat_bytes = {pattern_high, pattern_low};
  assign rep_bytes = {replace_high, replace_low};
  assign len_write = cfg_valid && (cfg_reg_t'(cfg_index) == REG_PATTERN_LEN);

  // Clamp the lengths to what the window and registers hold
  always_comb begin
    if (pattern_len == '0) begin
      plen_eff = LEN_W'(1);
    end else if (pattern_len > LEN_W'(WIN)) begin
      plen_eff = LEN_W'(WIN);
    end else begin
      plen_eff = pattern_len;
    end
    if (replace_len > LEN_W'(REP)) begin
      rlen_eff = LEN_W'(REP);
    end else begin
      rlen_eff = replace_len;
    end
  end

  assign plen_c = CW'(plen_eff);
  assign wr_pos = (count >= plen_c) ? '0 : count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_low  <= '0;
      pattern_high <= '0;
      pattern_len  <= LEN_W'(1);
      replace_low  <= '0;
      replace_high <= '0;
      replace_len  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PATTERN_LOW:  pattern_low  <= cfg_data;
        REG_PATTERN_HIGH: pattern_high <= cfg_data;
        REG_PATTERN_LEN:  pattern_len  <= cfg_data[LEN_W-1:0];
        REG_REPLACE_LOW:  replace_low  <= cfg_data;
        REG_REPLACE_HIGH: replace_high <= cfg_data;
        REG_REPLACE_LEN:  replace_len  <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Compare every active window byte against the pattern
  always_comb begin
    match = 1'b1;
    for (int k = 0; k < WIN; k++) begin
      if ((CW'(k) < plen_c) && (window[k] != pat_bytes[k])) begin
        match = 1'b0;
      end
    end
  end

  // Window storage: write at the fill point, shift on pop
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < WIN; k++) begin
        if (wr_pos == CW'(k)) begin
          window[k] <= in_byte;
        end
      end
    end else if (cmd.pop) begin
      for (int k = 0; k < WIN - 1; k++) begin
        window[k] <= window[k + 1];
      end
    end
  end

  // Fill count and replacement index
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rep_idx <= '0;
    end else begin
      if (len_write) begin
        count <= '0;
      end else if (cmd.load) begin
        count <= wr_pos + CW'(1);
      end else if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end
      if (cmd.rep_start) begin
        rep_idx <= '0;
      end else if (cmd.rep_emit) begin
        rep_idx <= rep_idx + RIW'(1);
      end
    end
  end

  // Select the beat to emit
  assign emit = cmd.pop || cmd.rep_emit || cmd.mark;
  always_comb begin
    if (cmd.pop) begin
      emit_byte = window[0];
    end else if (cmd.rep_emit) begin
      emit_byte = rep_bytes[4'(rep_idx)];
    end else begin
      emit_byte = '0;
    end
  end

  // Output register valid and position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pos       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (emit && cmd.final_beat) begin
        pos <= '0;
      end else if (emit && (pos != PW'(MAX_OUTPUT))) begin
        pos <= pos + PW'(1);
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte <= emit_byte;
      out_last <= cmd.final_beat;
      overflow <= !cmd.mark && (pos == PW'(MAX_OUTPUT));
    end
  end

  // Status back to the controller
  always_comb begin
    st.slot_free = !out_valid || out_ready;
    st.full      = (count == plen_c);
    st.match     = match;
    st.count_one = (count == CW'(1));
    st.rep_end   = ((LEN_W'(rep_idx) + LEN_W'(1)) == rlen_eff);
    st.rlen_zero = (rlen_eff == '0);
  end

endmodule

`default_nettype wire

// ----- rtl/stream_substring_replace.sv -----
// Top level of the streaming substring replace block.
// Depends on ssr_pkg, ssr_ctrl and ssr_datapath.
//
// Rewrites a byte string, one byte per input beat with tlast on the final
// byte, replacing every leftmost non-overlapping occurrence of the pattern
// (1 to 16 bytes) by the replacement (0 to 16 bytes). Output beats carry
// the byte in tdata, tlast on the final byte of the string and, in tuser,
// an overflow flag for bytes at output position MAX_OUTPUT or beyond. A
// string whose final input produces no byte still ends with one beat:
// tdata zero, tlast high, tuser low. For each input byte the state machine
// accepts the byte, evaluates the window compare in the next cycle, then
// sends beats one per cycle, unless the output side stalls, through a
// single output register; it takes no new byte until those beats are sent.
// Configure only while the block is idle; writing pattern_len discards
// pending window bytes.
`timescale 1ns / 1ps
`default_nettype none

module stream_substring_replace #(
  parameter int MAX_PATTERN = ssr_pkg::DEF_MAX_PATTERN,
  parameter int MAX_REPLACE = ssr_pkg::DEF_MAX_REPLACE,
  parameter int MAX_OUTPUT  = ssr_pkg::DEF_MAX_OUTPUT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,  // [7:0] in_byte
  input  wire logic                           s_axis_tlast,  // in_last
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,  // [7:0] out_byte
  output logic                                m_axis_tlast,  // out_last
  output logic                                m_axis_tuser,  // [0] overflow
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ssr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ssr_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  // Registers always take a write
  assign cfg_ready = 1'b1;

  ssr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .in_ready (s_axis_tready),
    .st       (st),
    .cmd      (cmd)
  );

  ssr_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE),
    .MAX_OUTPUT  (MAX_OUTPUT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_byte   (s_axis_tdata),
    .cmd       (cmd),
    .st        (st),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast),
    .overflow  (m_axis_tuser)
  );

  // At most one datapath operation per cycle
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.pop, cmd.rep_emit, cmd.mark}))
    else $error("more than one datapath operation in a cycle");

  // Never overwrite a beat the output side has not taken
  a_slot_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.pop || cmd.rep_emit || cmd.mark) |-> (!m_axis_tvalid || m_axis_tready))
    else $error("output beat overwritten before it was taken");

  // An accepted byte is evaluated before the next one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken while previous byte still pending");

endmodule

`default_nettype wire
